/* design/exm_pkg.sv */
// exm_pkg: shared types and constants for the exact pattern matcher.
// Used by exm_cell, exact_pattern_matcher and exm_checker; no dependencies.
package exm_pkg;

  localparam int BYTE_W     = 8;
  localparam int POS_W      = 32;
  localparam int LEN_W      = 5;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int PAT_BYTES  = 16;
  localparam int PAT_IDX_W  = 4;
  localparam int WORD_BYTES = CFG_W / BYTE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2,
    REG_UNUSED   = 2'd3
  } cfg_reg_t;

  typedef logic [BYTE_W-1:0] byte_t;

  // shift control common to every cell in the row
  typedef struct packed {
    logic load;
    logic clear;
  } cell_ctrl_t;

endpackage

/* design/exm_cell.sv */
// exm_cell: one window slot of the matcher row - holds a byte, passes it on,
// and registers whether the incoming byte equals its pattern byte. Uses exm_pkg.
module exm_cell (
  input  logic                clk,
  input  logic                rst,
  input  exm_pkg::cell_ctrl_t ctrl,
  input  exm_pkg::byte_t      din,
  input  exm_pkg::byte_t      pat_byte,
  input  logic                active,
  output exm_pkg::byte_t      dout,
  output logic                match
);

  exm_pkg::byte_t slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (ctrl.load) begin
      slot <= ctrl.clear ? '0 : din;
    end
  end

  // compare the byte as it enters; inactive slots always agree
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      match <= !active || (din == pat_byte);
    end
  end

  assign dout = slot;

endmodule

/* design/exact_pattern_matcher.sv */
// exact_pattern_matcher: top level - a row of exm_cell window slots, a
// sequence byte counter and a two-stage result path. Uses exm_pkg, exm_cell.
//
// Usage:
//  - Input channel (in_valid/in_ready): one sequence byte per beat, seq_last
//    marks the final byte of a sequence; the next beat starts at position 0.
//  - Output channel (out_valid/out_ready): one beat per occurrence, carrying
//    the zero-based start position of the pattern in the current sequence.
//    Overlapping hits are all reported; the byte count saturates at all ones.
//  - Configuration: cfg_wen/cfg_index/cfg_data, no handshake. Index 0 holds
//    pattern bytes 0-7, index 1 bytes 8-15, index 2 the length (1-16; 0
//    disables, longer values act as MAX_PATTERN). Write only while idle.
//  - Result path: a hit is registered in the compare stage, then in the output register.
//  - Throughput: one byte per cycle while in_ready is high; each byte shifts one slot down the cell
//    row and every slot compares in parallel, so the row sets the rate.
//  - Stall: while out_ready is low one hit waits in the output register and
//    a second in the compare stage; in_ready drops only when both are full.
//    Bytes without a hit keep flowing until both are full.
//  - Reset (rst, synchronous): window zeroed, count cleared, pattern all zero
//    with length 1, both stages emptied.
module exact_pattern_matcher #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // sequence in
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [exm_pkg::BYTE_W-1:0]     seq_char,
  input  logic                           seq_last,
  // occurrences out
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [exm_pkg::POS_W-1:0]      match_position,
  // configuration
  input  logic                           cfg_wen,
  input  logic [exm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [exm_pkg::CFG_W-1:0]      cfg_data
);

  // ---- configuration registers ----
  logic [exm_pkg::CFG_W-1:0] pat_low;
  logic [exm_pkg::CFG_W-1:0] pat_high;
  logic [exm_pkg::LEN_W-1:0] pat_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low  <= '0;
      pat_high <= '0;
      pat_len  <= exm_pkg::LEN_W'(1);
    end else if (cfg_wen) begin
      unique case (exm_pkg::cfg_reg_t'(cfg_index))
        exm_pkg::REG_PAT_LOW:  pat_low  <= cfg_data;
        exm_pkg::REG_PAT_HIGH: pat_high <= cfg_data;
        exm_pkg::REG_PAT_LEN:  pat_len  <= cfg_data[exm_pkg::LEN_W-1:0];
        default: ;  // writes past the list are dropped
      endcase
    end
  end

  // pattern as a byte array, byte 0 from the low word
  exm_pkg::byte_t pat_bytes [exm_pkg::PAT_BYTES];

  always_comb begin
    for (int b = 0; b < exm_pkg::WORD_BYTES; b++) begin
      pat_bytes[b]                       = pat_low[b*exm_pkg::BYTE_W +: exm_pkg::BYTE_W];
      pat_bytes[b+exm_pkg::WORD_BYTES]   = pat_high[b*exm_pkg::BYTE_W +: exm_pkg::BYTE_W];
    end
  end

  // clamp length to the row size; zero means matching is off
  localparam logic [exm_pkg::LEN_W-1:0] MaxLen = exm_pkg::LEN_W'(MAX_PATTERN);

  logic [exm_pkg::LEN_W-1:0] eff_len;
  logic [exm_pkg::LEN_W-1:0] len_m1;
  logic                      len_on;

  assign eff_len = (pat_len > MaxLen) ? MaxLen : pat_len;
  assign len_on  = (eff_len != '0);
  assign len_m1  = eff_len - exm_pkg::LEN_W'(1);

  // ---- handshake / flow control ----
  logic in_fire;
  logic out_free;
  logic s1_valid;
  logic s1_ok;
  logic s1_hit;
  logic s1_free;
  logic [exm_pkg::POS_W-1:0] s1_pos;

  assign out_free = !out_valid || out_ready;
  assign s1_free  = !s1_hit || out_free;
  assign in_ready = s1_free;
  assign in_fire  = in_valid && in_ready;

  // ---- cell row: cell k holds the byte k places back from the newest ----
  exm_pkg::cell_ctrl_t ctrl;
  exm_pkg::byte_t      chain  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_match;

  assign ctrl.load  = in_fire;
  assign ctrl.clear = seq_last;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [exm_pkg::LEN_W-1:0]     k_pos;
    logic [exm_pkg::LEN_W-1:0]     rel;
    logic                          active;
    exm_pkg::byte_t                din;

    assign k_pos  = exm_pkg::LEN_W'(k);
    assign active = (k_pos < eff_len);
    // slot k lines up with pattern byte len-1-k
    assign rel    = len_m1 - k_pos;

    if (k == 0) begin : g_head
      assign din = seq_char;
    end else begin : g_body
      assign din = chain[k-1];
    end

    exm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .din      (din),
      .pat_byte (pat_bytes[rel[exm_pkg::PAT_IDX_W-1:0]]),
      .active   (active),
      .dout     (chain[k]),
      .match    (cell_match[k])
    );
  end

  // ---- byte counter and start position ----
  logic [exm_pkg::POS_W-1:0] bytes_seen;
  logic [exm_pkg::POS_W:0]   diff;

  // start = (seen + 1) - len = seen - (len - 1); borrow means too few bytes
  assign diff = {1'b0, bytes_seen} - (exm_pkg::POS_W+1)'(len_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
    end else if (in_fire) begin
      if (seq_last) begin
        bytes_seen <= '0;
      end else if (bytes_seen != '1) begin
        bytes_seen <= bytes_seen + exm_pkg::POS_W'(1);
      end
    end
  end

  // ---- compare stage ----
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ok  <= len_on && !diff[exm_pkg::POS_W];
      s1_pos <= diff[exm_pkg::POS_W-1:0];
    end
  end

  assign s1_hit = s1_valid && s1_ok && (&cell_match);

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_hit) begin
      match_position <= s1_pos;
    end
  end

endmodule

/* design/exm_checker.sv */
// exm_checker: port-level assertions for exact_pattern_matcher, bound to it below.
// Uses exm_pkg for widths.
module exm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [exm_pkg::POS_W-1:0]     match_position
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(match_position))
    else $error("result beat changed while stalled");

  // reset empties the output
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // a new result needs an accepted byte beat in an earlier cycle
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result beat without a causing byte");

  // input back-pressure only while a result is held at the output
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without an output stall");

endmodule

bind exact_pattern_matcher exm_checker u_exm_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .match_position (match_position)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for exact_pattern_matcher, directed table then random phases.
// Depends on exm_pkg and the matcher RTL; carries its own byte-window predictor.
module tb;

  localparam int N_DIRECTED  = 22;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [0:0] {ROW_BYTE, ROW_CFG} row_kind_t;
  // how a byte row is checked: by the predictor, nothing expected, or a typed position
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_AT} row_chk_t;

  typedef struct packed {
    row_kind_t                 kind;
    exm_pkg::cfg_reg_t         idx;
    logic [exm_pkg::CFG_W-1:0] data;
    exm_pkg::byte_t            ch;
    logic                      last;
    row_chk_t                  chk;
    logic [exm_pkg::POS_W-1:0] pos;
  } dir_row_t;

  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // reset pattern is a single zero byte
    '{ROW_BYTE, exm_pkg::REG_PAT_LOW,  64'h0,     8'h00, 1'b0, CHK_AT,    32'd0},
    '{ROW_BYTE, exm_pkg::REG_PAT_LOW,  64'h0,     8'hFF, 1'b0, CHK_NONE,  32'd0},
    '{ROW_BYTE, exm_pkg::REG_PAT_LOW,  64'h0,     8'h00, 1'b1, CHK_AT,    32'd2},
    // end of sequence: count restarts at zero
    '{ROW_BYTE, exm_pkg::REG_PAT_LOW,  64'h0,     8'h00, 1'b0, CHK_AT,    32'd0},
    // zero length switches matching off
    '{ROW_CFG,  exm_pkg::REG_PAT_LEN,  64'h0,     8'h00, 1'b0, CHK_NONE,  32'd0},
    '{ROW_BYTE, exm_pkg::REG_PAT_LOW,  64'h0,     8'h00, 1'b0, CHK_NONE,  32'd0},
    '{ROW_BYTE, exm_pkg::REG_PAT_LOW,  64'h0,     8'h00, 1'b1, CHK_NONE,  32'd0},
    // two-byte pattern, repeated runs, match broken by a last beat
    '{ROW_CFG,  exm_pkg::REG_PAT_LOW,  64'h4241,  8'h00, 1'b0, CHK_NONE,  32'd0},
    '{ROW_CFG,  exm_pkg::REG_PAT_HIGH, '1,        8'h00, 1'b0, CHK_NONE,  32'd0},
    '{ROW_CFG,  exm_pkg::REG_PAT_LEN,  64'h2,     8'h00, 1'b0, CHK_NONE,  32'd0},
    '{ROW_BYTE, exm_pkg::REG_PAT_LOW,  64'h0,     8'h41, 1'b0, CHK_MODEL, 32'd0},
    '{ROW_BYTE, exm_pkg::REG_PAT_LOW,  64'h0,     8'h42, 1'b0, CHK_MODEL, 32'd0},
    '{ROW_BYTE, exm_pkg::REG_PAT_LOW,  64'h0,     8'h41, 1'b0, CHK_MODEL, 32'd0},
    '{ROW_BYTE, exm_pkg::REG_PAT_LOW,  64'h0,     8'h42, 1'b0, CHK_MODEL, 32'd0},
    '{ROW_BYTE, exm_pkg::REG_PAT_LOW,  64'h0,     8'h41, 1'b1, CHK_MODEL, 32'd0},
    '{ROW_BYTE, exm_pkg::REG_PAT_LOW,  64'h0,     8'h42, 1'b0, CHK_MODEL, 32'd0},
    // write to the spare index must leave everything alone
    '{ROW_CFG,  exm_pkg::REG_UNUSED,   '1,        8'h00, 1'b0, CHK_NONE,  32'd0},
    '{ROW_BYTE, exm_pkg::REG_PAT_LOW,  64'h0,     8'h41, 1'b0, CHK_MODEL, 32'd0},
    '{ROW_BYTE, exm_pkg::REG_PAT_LOW,  64'h0,     8'h42, 1'b1, CHK_MODEL, 32'd0},
    // all-ones byte as a one-byte pattern
    '{ROW_CFG,  exm_pkg::REG_PAT_LOW,  64'hFF,    8'h00, 1'b0, CHK_NONE,  32'd0},
    '{ROW_CFG,  exm_pkg::REG_PAT_LEN,  64'h1,     8'h00, 1'b0, CHK_NONE,  32'd0},
    '{ROW_BYTE, exm_pkg::REG_PAT_LOW,  64'h0,     8'hFF, 1'b0, CHK_AT,    32'd0}
  };

  logic                          clk;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic [exm_pkg::BYTE_W-1:0]    seq_char  = '0;
  logic                          seq_last  = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [exm_pkg::POS_W-1:0]     match_position;
  logic                          cfg_wen   = 1'b0;
  logic [exm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [exm_pkg::CFG_W-1:0]     cfg_data  = '0;

  exact_pattern_matcher uut (
    .clk, .rst,
    .in_valid, .in_ready, .seq_char, .seq_last,
    .out_valid, .out_ready, .match_position,
    .cfg_wen, .cfg_index, .cfg_data
  );

  // predictor state, reset values
  exm_pkg::byte_t            window [exm_pkg::PAT_BYTES] = '{default: '0};  // [0] is newest
  logic [exm_pkg::POS_W-1:0] seen    = '0;
  logic [exm_pkg::CFG_W-1:0] pat_lo  = '0;
  logic [exm_pkg::CFG_W-1:0] pat_hi  = '0;
  logic [exm_pkg::LEN_W-1:0] pat_len = exm_pkg::LEN_W'(1);

  logic [exm_pkg::POS_W-1:0] hit_positions [$];
  int                        mismatches    = 0;
  int                        send_idle_pct = 15;
  int                        recv_idle_pct = 56;
  int                        phase_no      = -1;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // one sequence byte through the window; reports a hit and its start position
  function automatic void scan_byte(input exm_pkg::byte_t ch, input logic last,
                                    output logic hit,
                                    output logic [exm_pkg::POS_W-1:0] pos);
    int                          k;
    int                          n_eff;
    logic [exm_pkg::POS_W:0]     count;
    logic [exm_pkg::POS_W:0]     start;
    logic [2*exm_pkg::CFG_W-1:0] pat;
    n_eff = (pat_len > exm_pkg::PAT_BYTES) ? exm_pkg::PAT_BYTES : int'(pat_len);
    pat = {pat_hi, pat_lo};
    for (k = exm_pkg::PAT_BYTES - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = ch;
    count = {1'b0, seen} + 1'b1;
    hit = 1'b0;
    pos = '0;
    if (n_eff != 0 && count >= n_eff) begin
      hit = 1'b1;
      for (k = 0; k < n_eff; k++)
        if (window[n_eff-1-k] != pat[8*k +: 8]) hit = 1'b0;
      start = count - (exm_pkg::POS_W+1)'(n_eff);
      pos = start[exm_pkg::POS_W] ? '1 : start[exm_pkg::POS_W-1:0];
    end
    // saturation of the count sits far beyond any run of this length
    if (last) begin
      seen = '0;
      window = '{default: '0};
    end else if (seen != '1) begin
      seen = seen + 1'b1;
    end
  endfunction

  // register write once the block has drained: sender off, all hits in, pipe flushed
  task automatic write_reg(input exm_pkg::cfg_reg_t idx,
                           input logic [exm_pkg::CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (hit_positions.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      exm_pkg::REG_PAT_LOW:  pat_lo = value;
      exm_pkg::REG_PAT_HIGH: pat_hi = value;
      exm_pkg::REG_PAT_LEN:  pat_len = value[exm_pkg::LEN_W-1:0];
      default: ;
    endcase
  endtask

  // offer one beat after a random gap; returns at the accepting edge
  task automatic offer_byte(input exm_pkg::byte_t ch, input logic last);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    seq_char <= ch;
    seq_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // receiver: checks each result beat, randomises ready, one long hold in phase 0
  initial begin : drain
    int                        hold_left;
    bit                        held;
    logic [exm_pkg::POS_W-1:0] want;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (hit_positions.size() == 0) begin
          $error("match_position: no beat expected, actual %0d", match_position);
          mismatches++;
        end else begin
          want = hit_positions.pop_front();
          if (match_position !== want) begin
            $error("match_position: expected %0d, actual %0d", want, match_position);
            mismatches++;
          end
        end
      end
      if (!held && phase_no == 0) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int                          i;
    int                          ph;
    int                          j;
    int                          r;
    int                          n_eff;
    int                          sent;
    dir_row_t                    row;
    exm_pkg::byte_t              alpha [2];
    exm_pkg::byte_t              pending [$];
    exm_pkg::byte_t              ch;
    logic                        last;
    logic                        hit;
    logic [exm_pkg::POS_W-1:0]   pos;
    logic [exm_pkg::LEN_W-1:0]   len_code;
    logic [2*exm_pkg::CFG_W-1:0] pat;
    logic [exm_pkg::CFG_W-1:0]   len_word;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_CFG) begin
        write_reg(row.idx, row.data);
      end else begin
        offer_byte(row.ch, row.last);
        scan_byte(row.ch, row.last, hit, pos);
        case (row.chk)
          CHK_MODEL: if (hit) hit_positions = {hit_positions, pos};
          CHK_AT:    hit_positions = {hit_positions, row.pos};
          default: ;
        endcase
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 15;
        recv_idle_pct = 56;
      end else if (ph < 6) begin
        send_idle_pct = 56;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // phase 0 is the one-byte case that fills the block under the long hold
      case (ph)
        0: len_code = exm_pkg::LEN_W'(1);
        1: len_code = exm_pkg::LEN_W'(16);
        2: len_code = '0;
        3: len_code = exm_pkg::LEN_W'($urandom_range(31, 17));
        default: begin
          r = $urandom_range(9);
          len_code = (r < 6) ? exm_pkg::LEN_W'($urandom_range(5, 2))
                             : exm_pkg::LEN_W'($urandom_range(16, 1));
        end
      endcase
      n_eff = (len_code > exm_pkg::PAT_BYTES) ? exm_pkg::PAT_BYTES : int'(len_code);

      // two-letter alphabet keeps hits frequent; unused pattern bytes stay random
      alpha[0] = exm_pkg::byte_t'($urandom);
      alpha[1] = exm_pkg::byte_t'($urandom);
      pat = {$urandom, $urandom, $urandom, $urandom};
      for (j = 0; j < n_eff; j++) pat[8*j +: 8] = alpha[$urandom_range(1)];
      len_word = {$urandom, $urandom};
      len_word[exm_pkg::LEN_W-1:0] = len_code;

      write_reg(exm_pkg::REG_PAT_LOW, pat[exm_pkg::CFG_W-1:0]);
      write_reg(exm_pkg::REG_PAT_HIGH, pat[2*exm_pkg::CFG_W-1:exm_pkg::CFG_W]);
      write_reg(exm_pkg::REG_PAT_LEN, len_word);
      if ($urandom_range(2) == 0) write_reg(exm_pkg::REG_UNUSED, {$urandom, $urandom});

      // receiver hold keys off this, so it starts with the sender running
      phase_no = ph;

      pending.delete();
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (pending.size() == 0) begin
          r = $urandom_range(99);
          if (r < 35 && n_eff > 0) begin
            for (j = 0; j < n_eff; j++) pending = {pending, pat[8*j +: 8]};
          end else if (r < 88) begin
            pending = {pending, alpha[$urandom_range(1)]};
          end else begin
            pending = {pending, exm_pkg::byte_t'($urandom)};
          end
        end
        ch = pending.pop_front();
        last = ($urandom_range(49) == 0);
        offer_byte(ch, last);
        scan_byte(ch, last, hit, pos);
        if (hit) hit_positions = {hit_positions, pos};
        sent++;
      end
    end

    in_valid <= 1'b0;
    while (hit_positions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
